@@ rtl/core/srr_pkg.sv @@
`timescale 1ns / 1ps
package srr_pkg;

  localparam int ADDR_W = 5;
  localparam logic [11:0] MAX_PAYLOAD = 12'd2048;

  localparam logic [2:0] REG_WINDOW  = 3'd0;
  localparam logic [2:0] REG_RESEND  = 3'd1;
  localparam logic [2:0] REG_RECEIVE = 3'd2;
  localparam logic [2:0] REG_MAGIC   = 3'd3;
  localparam logic [2:0] REG_FLAG    = 3'd4;
  localparam logic [2:0] REG_MINLEN  = 3'd5;

  localparam logic [1:0] CMD_PACKET = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_RESEND  = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_DEL,
    S_ACK,
    S_CHKCRED,
    S_DONE,
    S_RESEND,
    S_STALE,
    S_DRAIN_START,
    S_PARK_START,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] window_size;
    logic [15:0] resend_timeout;
    logic [15:0] receive_timeout;
    logic [15:0] protocol_magic;
    logic [7:0]  data_flag_code;
    logic [11:0] min_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [11:0] len;
    logic [7:0]  handle;
    logic [11:0] offset;
  } slot_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [7:0]  handle;
    logic [11:0] offset;
    logic [11:0] length;
  } res_t;

endpackage

@@ rtl/core/srr_ram.sv @@
`timescale 1ns / 1ps
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/srr_cfg.sv @@
`timescale 1ns / 1ps
module srr_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [srr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output srr_pkg::cfg_t             cfg
);
  import srr_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size     <= 32'd65536;
      cfg.resend_timeout  <= 16'd100;
      cfg.receive_timeout <= 16'd1000;
      cfg.protocol_magic  <= 16'd0;
      cfg.data_flag_code  <= 8'd1;
      cfg.min_frame_bytes <= 12'd62;
    end else if (wr) begin
      case (idx)
        REG_WINDOW:  cfg.window_size     <= pwdata;
        REG_RESEND:  cfg.resend_timeout  <= pwdata[15:0];
        REG_RECEIVE: cfg.receive_timeout <= pwdata[15:0];
        REG_MAGIC:   cfg.protocol_magic  <= pwdata[15:0];
        REG_FLAG:    cfg.data_flag_code  <= pwdata[7:0];
        REG_MINLEN:  cfg.min_frame_bytes <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW:  prdata = cfg.window_size;
      REG_RESEND:  prdata = {16'd0, cfg.resend_timeout};
      REG_RECEIVE: prdata = {16'd0, cfg.receive_timeout};
      REG_MAGIC:   prdata = {16'd0, cfg.protocol_magic};
      REG_FLAG:    prdata = {24'd0, cfg.data_flag_code};
      REG_MINLEN:  prdata = {20'd0, cfg.min_frame_bytes};
      default:     prdata = 32'd0;
    endcase
  end
endmodule

@@ rtl/core/stream_reorder_receiver.sv @@
`timescale 1ns / 1ps
// Reorder receiver for a sequenced byte stream. Commands arrive on the input
// channel (in_valid/in_stall): packet descriptor, read request, tick, stream
// reset. Each item yields zero or more result items on the output channel
// (out_valid/out_stall), the last of them flagged by out_last. Payload bytes
// stay in external buffers and are named by handle and offset.
// One item is worked on at a time; in_stall is high from acceptance until its
// last result has been handed to the output register. With no read active a
// packet or tick is finished without a scan of the slot memory. With a read
// active, an item that does not end the read ends with a scan of the slot
// memory, one entry a cycle; a park that fits the window and each slot
// drained add a further scan.
// A stalled output holds its item; one further result waits in an internal
// register and the sequencer then waits, so nothing is lost.
// Synchronous reset clears the stream state, the read and all slot valid
// bits, and restores the configuration defaults; no clearing pass is needed.
module stream_reorder_receiver #(
  parameter int REORDER_SLOTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                command,
  input  logic [11:0]               frame_len,
  input  logic [15:0]               hdr_magic,
  input  logic [7:0]                hdr_flags,
  input  logic [31:0]               pkt_seq,
  input  logic [11:0]               payload_len,
  input  logic [7:0]                buf_handle,
  input  logic [19:0]               want_bytes,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [31:0]               out_value,
  output logic [7:0]                out_handle,
  output logic [11:0]               out_offset,
  output logic [11:0]               out_length,
  output logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [srr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import srr_pkg::*;

  localparam int IW = (REORDER_SLOTS > 1) ? $clog2(REORDER_SLOTS) : 1;
  localparam int CW = $clog2(REORDER_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(REORDER_SLOTS - 1);
  localparam logic [CW-1:0] SLOT_CNT = CW'(REORDER_SLOTS);

  cfg_t   cfg;
  state_t state, state_next;

  // Latched item.
  logic [1:0]  c_cmd;
  logic [11:0] c_frame_len;
  logic [15:0] c_magic;
  logic [7:0]  c_flags;
  logic [31:0] c_seq;
  logic [11:0] c_plen;
  logic [7:0]  c_handle;
  logic [19:0] c_want;

  // Stream state.
  logic [31:0] exp_seq;
  logic [19:0] credit;
  logic [19:0] bytes_rcvd;
  logic        active;
  logic [15:0] prog_age;
  logic [15:0] res_age;
  logic [REORDER_SLOTS-1:0] slot_vld;

  // Delivery and park operands.
  logic [7:0]    d_handle;
  logic [11:0]   d_off;
  logic [11:0]   d_len;
  logic          d_from_slot;
  logic [IW-1:0] d_idx;
  logic [31:0]   d_seq;
  logic [31:0]   p_seq;
  logic [11:0]   p_len;
  logic [7:0]    p_handle;
  logic [11:0]   p_off;
  logic          park_ahead;

  // Table scan.
  logic          scan_park;
  logic [CW-1:0] scan_cnt;
  logic          cmp_valid;
  logic [IW-1:0] cmp_idx;

  // Result path.
  logic pend_valid;
  res_t pend;
  res_t out_q;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata;
  slot_t         ram_rdata;

  logic [11:0] take;
  logic        pkt_ok;
  logic [15:0] prog_inc;
  logic [15:0] res_inc;
  logic        park_fits;
  logic [31:0] scan_key;
  logic        scan_hit;
  logic        scan_end;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic        out_free;
  logic        pend_room;
  logic        emit_req;
  res_t        emit_res;
  logic        emit_go;
  logic        step_ok;
  logic        fin_push;
  logic        out_push;
  state_t      park_done_state;

  srr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srr_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (REORDER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  assign take = (credit < {8'd0, d_len}) ? credit[11:0] : d_len;
  assign pkt_ok = (c_frame_len >= cfg.min_frame_bytes) && (c_magic == cfg.protocol_magic) &&
                  (c_flags == cfg.data_flag_code) && (c_plen <= MAX_PAYLOAD);
  assign prog_inc = (prog_age == 16'hFFFF) ? prog_age : prog_age + 16'd1;
  assign res_inc  = (res_age == 16'hFFFF) ? res_age : res_age + 16'd1;
  assign park_fits = (p_len != 12'd0) && (p_seq >= exp_seq) &&
                     ((p_seq - exp_seq) <= cfg.window_size);
  assign scan_key = scan_park ? p_seq : exp_seq;
  assign scan_hit = cmp_valid && slot_vld[cmp_idx] && (ram_rdata.seq == scan_key);
  assign scan_end = cmp_valid && (cmp_idx == LAST_IDX);
  assign park_done_state = park_ahead ? S_RESEND : S_CHKCRED;

  always_comb begin
    free_found = ~&slot_vld;
    free_idx   = '0;
    for (int i = REORDER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_vld[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign pend_room = !pend_valid || out_free;

  // Result generated by the current state.
  always_comb begin
    emit_req = 1'b0;
    emit_res = '{kind: KIND_ACK, value: 32'd0, handle: 8'd0, offset: 12'd0, length: 12'd0};
    case (state)
      S_DEL: begin
        emit_req = (take != 12'd0);
        emit_res.kind   = KIND_DELIVER;
        emit_res.handle = d_handle;
        emit_res.offset = d_off;
        emit_res.length = take;
      end
      S_ACK: begin
        emit_req = 1'b1;
        emit_res.value = exp_seq + {20'd0, d_len};
      end
      S_DONE: begin
        emit_req = 1'b1;
        emit_res.kind  = KIND_DONE;
        emit_res.value = {12'd0, bytes_rcvd};
      end
      S_RESEND: begin
        emit_req = 1'b1;
        emit_res.kind  = KIND_RESEND;
        emit_res.value = exp_seq;
      end
      S_STALE: begin
        emit_req = 1'b1;
        emit_res.value = exp_seq;
      end
      default: ;
    endcase
  end

  assign emit_go  = emit_req && pend_room;
  assign step_ok  = !emit_req || pend_room;
  assign fin_push = (state == S_FINISH) && pend_valid && out_free;
  assign out_push = (emit_go && pend_valid) || fin_push;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_CMD;
      S_CMD: begin
        case (c_cmd)
          CMD_PACKET: begin
            if (!active) state_next = S_FINISH;
            else if (!pkt_ok) state_next = S_DRAIN_START;
            else if (c_seq == exp_seq) state_next = S_DEL;
            else if (c_seq > exp_seq) state_next = S_PARK_START;
            else state_next = S_STALE;
          end
          CMD_READ: state_next = (c_want == 20'd0) ? S_DONE : S_DRAIN_START;
          CMD_TICK: begin
            if (!active) state_next = S_FINISH;
            else if (prog_inc > cfg.receive_timeout) state_next = S_DONE;
            else if (res_inc > cfg.resend_timeout) state_next = S_RESEND;
            else state_next = S_DRAIN_START;
          end
          default: state_next = S_DRAIN_START;
        endcase
      end
      S_DEL: if (step_ok) state_next = S_ACK;
      S_ACK: begin
        if (step_ok) begin
          if (!d_from_slot && (take < d_len)) state_next = S_PARK_START;
          else state_next = S_CHKCRED;
        end
      end
      S_CHKCRED: state_next = (credit == 20'd0) ? S_DONE : S_DRAIN_START;
      S_DONE:    if (step_ok) state_next = S_DRAIN_START;
      S_RESEND:  if (step_ok) state_next = S_DRAIN_START;
      S_STALE:   if (step_ok) state_next = S_DRAIN_START;
      S_DRAIN_START: state_next = active ? S_SCAN : S_FINISH;
      S_PARK_START:  state_next = park_fits ? S_SCAN : park_done_state;
      S_SCAN: begin
        if (scan_hit) state_next = scan_park ? park_done_state : S_DEL;
        else if (scan_end) state_next = scan_park ? park_done_state : S_FINISH;
      end
      S_FINISH: if (!pend_valid || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Slot memory write: a partly drained slot, or a newly parked packet.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = d_idx;
    ram_wdata = '{seq: d_seq + {20'd0, take}, len: d_len - take, handle: d_handle,
                  offset: d_off + take};
    if (state == S_ACK && step_ok && d_from_slot && (take < d_len)) begin
      ram_we = 1'b1;
    end else if (state == S_SCAN && scan_park && !scan_hit && scan_end && free_found) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = '{seq: p_seq, len: p_len, handle: p_handle, offset: p_off};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      exp_seq    <= 32'd0;
      credit     <= 20'd0;
      bytes_rcvd <= 20'd0;
      active     <= 1'b0;
      prog_age   <= 16'd0;
      res_age    <= 16'd0;
      slot_vld   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      cmp_valid  <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      state <= state_next;

      out_valid <= out_push || (out_valid && out_stall);
      if (out_push) begin
        out_q     <= pend;
        out_last  <= fin_push;
      end
      if (emit_go) begin
        pend       <= emit_res;
        pend_valid <= 1'b1;
      end else if (fin_push) begin
        pend_valid <= 1'b0;
      end

      if (ram_we && state == S_SCAN) slot_vld[free_idx] <= 1'b1;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_cmd       <= command;
            c_frame_len <= frame_len;
            c_magic     <= hdr_magic;
            c_flags     <= hdr_flags;
            c_seq       <= pkt_seq;
            c_plen      <= payload_len;
            c_handle    <= buf_handle;
            c_want      <= want_bytes;
          end
        end
        S_CMD: begin
          case (c_cmd)
            CMD_PACKET: begin
              d_handle    <= c_handle;
              d_off       <= 12'd0;
              d_len       <= c_plen;
              d_from_slot <= 1'b0;
              p_seq       <= c_seq;
              p_len       <= c_plen;
              p_handle    <= c_handle;
              p_off       <= 12'd0;
              park_ahead  <= 1'b1;
            end
            CMD_READ: begin
              credit     <= c_want;
              bytes_rcvd <= 20'd0;
              prog_age   <= 16'd0;
              res_age    <= 16'hFFFF;
              active     <= 1'b1;
            end
            CMD_TICK: begin
              if (active) begin
                prog_age <= prog_inc;
                if (prog_inc <= cfg.receive_timeout) res_age <= res_inc;
              end
            end
            default: exp_seq <= 32'd0;
          endcase
        end
        S_ACK: begin
          if (step_ok) begin
            bytes_rcvd <= bytes_rcvd + {8'd0, take};
            credit     <= credit - {8'd0, take};
            exp_seq    <= exp_seq + {20'd0, take};
            prog_age   <= 16'd0;
            p_seq      <= exp_seq + {20'd0, take};
            p_len      <= d_len - take;
            p_handle   <= d_handle;
            p_off      <= take;
            park_ahead <= 1'b0;
            if (d_from_slot && (take == d_len)) slot_vld[d_idx] <= 1'b0;
          end
        end
        S_DONE:   if (step_ok) active <= 1'b0;
        S_RESEND: if (step_ok) res_age <= 16'd0;
        S_DRAIN_START: begin
          scan_park <= 1'b0;
          scan_cnt  <= '0;
          cmp_valid <= 1'b0;
        end
        S_PARK_START: begin
          scan_park <= 1'b1;
          scan_cnt  <= '0;
          cmp_valid <= 1'b0;
        end
        S_SCAN: begin
          if (scan_cnt < SLOT_CNT) begin
            scan_cnt  <= scan_cnt + CW'(1);
            cmp_valid <= 1'b1;
            cmp_idx   <= scan_cnt[IW-1:0];
          end else begin
            cmp_valid <= 1'b0;
          end
          if (scan_hit && !scan_park) begin
            d_seq       <= ram_rdata.seq;
            d_len       <= ram_rdata.len;
            d_handle    <= ram_rdata.handle;
            d_off       <= ram_rdata.offset;
            d_from_slot <= 1'b1;
            d_idx       <= cmp_idx;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_kind   = out_q.kind;
  assign out_value  = out_q.value;
  assign out_handle = out_q.handle;
  assign out_offset = out_q.offset;
  assign out_length = out_q.length;
endmodule

@@ rtl/core/srr_check.sv @@
`timescale 1ns / 1ps
module srr_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [31:0] out_value,
  input logic [7:0]  out_handle,
  input logic [11:0] out_offset,
  input logic [11:0] out_length,
  input logic        out_last
);
  import srr_pkg::*;

  // An item is worked on alone: the cycle after acceptance the input is held off.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // Held result stays valid with kind, value, length and last flag unchanged while the output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_kind) &&
      $stable(out_length) && $stable(out_last))
    else $error("stalled result changed");

  // Deliveries always carry bytes; other kinds carry no buffer reference.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DELIVER |-> out_length != 12'd0 && out_value == 32'd0)
    else $error("empty delivery");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_DELIVER |->
      out_length == 12'd0 && out_handle == 8'd0 && out_offset == 12'd0)
    else $error("buffer reference on a non-delivery result");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented straight after reset");
endmodule

bind stream_reorder_receiver srr_check u_srr_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_kind   (out_kind),
  .out_value  (out_value),
  .out_handle (out_handle),
  .out_offset (out_offset),
  .out_length (out_length),
  .out_last   (out_last)
);
